@@ design/rmq_pkg.sv @@
// shared constants and helpers for the rotation matrix to quaternion pipeline
package rmq_pkg;

  // field formats
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 20;
  localparam int D_W           = FIELD_W + 1;  // sum or difference of two entries
  localparam int Q_W           = 21;           // quotient bits, covers the 20-bit range plus one
  localparam int SAT_MAX       = 524287;
  localparam int SAT_MIN       = -524288;

  // branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_R0C0  = 2'd1;
  localparam logic [1:0] BR_R1C1  = 2'd2;
  localparam logic [1:0] BR_R2C2  = 2'd3;

  // component lanes
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;
  localparam logic [1:0] LANE_W = 2'd3;

  // lane that takes its value from the square root
  function automatic logic [1:0] main_lane(input logic [1:0] br);
    logic [1:0] lane;
    case (br)
      BR_TRACE: lane = LANE_W;
      BR_R0C0:  lane = LANE_X;
      BR_R1C1:  lane = LANE_Y;
      BR_R2C2:  lane = LANE_Z;
      default:  lane = LANE_W;
    endcase
    return lane;
  endfunction

endpackage

@@ design/rotation_matrix_to_quaternion.sv @@
// rotation matrix to quaternion (shepperd) as a deep pipeline
//
//  channel   direction  handshake          payload
//  input     in         valid_i / stall_o  entry_r0c0_i .. entry_r2c2_i
//  output    out        valid_o / stall_i  quat_x_o .. quat_w_o, branch_taken_o, bad_input_o
//
// one request enters per cycle while stall_o is low; the pipeline computes one square-root digit per
// stage followed by one quotient bit per stage
// all stages advance together; a stalled output freezes the whole pipeline in place
// stall_o is high only while a finished request waits and stall_i is high
// reset clears the valid bits only
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [FIELD_W-1:0] entry_r0c0_i,
  input  logic signed [FIELD_W-1:0] entry_r0c1_i,
  input  logic signed [FIELD_W-1:0] entry_r0c2_i,
  input  logic signed [FIELD_W-1:0] entry_r1c0_i,
  input  logic signed [FIELD_W-1:0] entry_r1c1_i,
  input  logic signed [FIELD_W-1:0] entry_r1c2_i,
  input  logic signed [FIELD_W-1:0] entry_r2c0_i,
  input  logic signed [FIELD_W-1:0] entry_r2c1_i,
  input  logic signed [FIELD_W-1:0] entry_r2c2_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [FIELD_W-1:0] quat_x_o,
  output logic signed [FIELD_W-1:0] quat_y_o,
  output logic signed [FIELD_W-1:0] quat_z_o,
  output logic signed [FIELD_W-1:0] quat_w_o,
  output logic [1:0]                branch_taken_o,
  output logic                      bad_input_o
);

  localparam int ARG_W = ((FRAC_BITS > D_W) ? FRAC_BITS : D_W) + 3;
  localparam int RAD_W = ARG_W - 1 + FRAC_BITS;
  localparam int SQ_W  = (RAD_W + 1) / 2;
  localparam int DEN_W = SQ_W + 1;
  localparam int CW    = DEN_W + Q_W;
  localparam int V_W   = ((Q_W > SQ_W) ? Q_W : SQ_W) + 2;
  localparam logic signed [ARG_W-1:0] ONE  = ARG_W'(1) << FRAC_BITS;
  localparam logic signed [V_W-1:0]   VMAX = V_W'(SAT_MAX);
  localparam logic signed [V_W-1:0]   VMIN = V_W'(SAT_MIN);

  logic adv;

  // global advance: hold everything while the output waits
  assign stall_o = valid_o && stall_i;
  assign adv     = !stall_o;

  // ---------------------------------------------------------------- setup
  logic signed [ARG_W-1:0] m00, m11, m22, tr, arg, arg_d;
  logic signed [D_W-1:0]   dv_d [4];
  logic [1:0]              br_d;
  logic                    neg_arg;

  always_comb begin
    m00 = ARG_W'(entry_r0c0_i);
    m11 = ARG_W'(entry_r1c1_i);
    m22 = ARG_W'(entry_r2c2_i);
    tr  = m00 + m11 + m22;
    for (int l = 0; l < 4; l++) dv_d[l] = '0;
    if (!tr[ARG_W-1]) begin
      br_d    = BR_TRACE;
      arg     = tr + ONE;
      dv_d[0] = D_W'(entry_r2c1_i) - D_W'(entry_r1c2_i);
      dv_d[1] = D_W'(entry_r0c2_i) - D_W'(entry_r2c0_i);
      dv_d[2] = D_W'(entry_r1c0_i) - D_W'(entry_r0c1_i);
    end else if (entry_r0c0_i >= entry_r1c1_i && entry_r0c0_i >= entry_r2c2_i) begin
      br_d    = BR_R0C0;
      arg     = m00 - (m11 + m22) + ONE;
      dv_d[1] = D_W'(entry_r0c1_i) + D_W'(entry_r1c0_i);
      dv_d[2] = D_W'(entry_r2c0_i) + D_W'(entry_r0c2_i);
      dv_d[3] = D_W'(entry_r2c1_i) - D_W'(entry_r1c2_i);
    end else if (entry_r1c1_i >= entry_r2c2_i) begin
      br_d    = BR_R1C1;
      arg     = m11 - (m22 + m00) + ONE;
      dv_d[0] = D_W'(entry_r0c1_i) + D_W'(entry_r1c0_i);
      dv_d[2] = D_W'(entry_r1c2_i) + D_W'(entry_r2c1_i);
      dv_d[3] = D_W'(entry_r0c2_i) - D_W'(entry_r2c0_i);
    end else begin
      br_d    = BR_R2C2;
      arg     = m22 - (m00 + m11) + ONE;
      dv_d[0] = D_W'(entry_r2c0_i) + D_W'(entry_r0c2_i);
      dv_d[1] = D_W'(entry_r1c2_i) + D_W'(entry_r2c1_i);
      dv_d[3] = D_W'(entry_r1c0_i) - D_W'(entry_r0c1_i);
    end
    neg_arg = arg[ARG_W-1];
    arg_d   = neg_arg ? '0 : arg;
  end

  // ---------------------------------------------------------------- square root stages
  logic                    sv_q   [SQ_W+1];
  logic [2*SQ_W-1:0]       rad_q  [SQ_W+1];
  logic [SQ_W-1:0]         root_q [SQ_W+1];
  logic [SQ_W+1:0]         srem_q [SQ_W+1];
  logic signed [D_W-1:0]   sdv_q  [SQ_W+1][4];
  logic [1:0]              sbr_q  [SQ_W+1];
  logic                    sflg_q [SQ_W+1];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q[0]  <= (2*SQ_W)'({arg_d[ARG_W-2:0], {FRAC_BITS{1'b0}}});
      root_q[0] <= '0;
      srem_q[0] <= '0;
      sdv_q[0]  <= dv_d;
      sbr_q[0]  <= br_d;
      sflg_q[0] <= neg_arg;
    end
  end

  // one root digit per stage
  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [SQ_W+1:0] rem_n, trial;
    logic            take;

    always_comb begin
      rem_n = {srem_q[k][SQ_W-1:0], rad_q[k][2*SQ_W-1 -: 2]};
      trial = {root_q[k], 2'b01};
      take  = rem_n >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (adv) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad_q[k+1]  <= {rad_q[k][2*SQ_W-3:0], 2'b00};
        root_q[k+1] <= {root_q[k][SQ_W-2:0], take};
        srem_q[k+1] <= take ? rem_n - trial : rem_n;
        sdv_q[k+1]  <= sdv_q[k];
        sbr_q[k+1]  <= sbr_q[k];
        sflg_q[k+1] <= sflg_q[k];
      end
    end
  end

  // ---------------------------------------------------------------- divide setup
  logic [SQ_W-1:0]  s_w;
  logic [CW-1:0]    num_d [4];
  logic             neg_d [4];
  logic [D_W-1:0]   mag   [4];

  always_comb begin
    s_w = (root_q[SQ_W] == '0) ? SQ_W'(1) : root_q[SQ_W];
    for (int l = 0; l < 4; l++) begin
      neg_d[l] = sdv_q[SQ_W][l][D_W-1];
      mag[l]   = neg_d[l] ? D_W'(-sdv_q[SQ_W][l]) : D_W'(sdv_q[SQ_W][l]);
      num_d[l] = (CW'(mag[l]) << FRAC_BITS) + CW'(s_w);
    end
  end

  logic                dv_q   [Q_W+1];
  logic [CW-1:0]       drem_q [Q_W+1][4];
  logic [Q_W-1:0]      dquo_q [Q_W+1][4];
  logic                dneg_q [Q_W+1][4];
  logic [DEN_W-1:0]    den_q  [Q_W+1];
  logic [SQ_W-2:0]     half_q [Q_W+1];
  logic [1:0]          dbr_q  [Q_W+1];
  logic                dflg_q [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= sv_q[SQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        drem_q[0][l] <= num_d[l];
        dquo_q[0][l] <= '0;
        dneg_q[0][l] <= neg_d[l];
      end
      den_q[0]  <= {s_w, 1'b0};
      half_q[0] <= s_w[SQ_W-1:1];
      dbr_q[0]  <= sbr_q[SQ_W];
      dflg_q[0] <= sflg_q[SQ_W];
    end
  end

  // one quotient bit per stage, four lanes side by side
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int SH = Q_W - 1 - j;
    logic [CW-1:0] shd;
    logic          take [4];

    always_comb begin
      shd = CW'(den_q[j]) << SH;
      for (int l = 0; l < 4; l++) take[l] = drem_q[j][l] >= shd;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 4; l++) begin
          drem_q[j+1][l] <= take[l] ? drem_q[j][l] - shd : drem_q[j][l];
          dquo_q[j+1][l] <= dquo_q[j][l] | (Q_W'(take[l]) << SH);
          dneg_q[j+1][l] <= dneg_q[j][l];
        end
        den_q[j+1]  <= den_q[j];
        half_q[j+1] <= half_q[j];
        dbr_q[j+1]  <= dbr_q[j];
        dflg_q[j+1] <= dflg_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- sign, select, saturate
  logic signed [V_W-1:0]     val   [4];
  logic signed [FIELD_W-1:0] comp_d[4];
  logic                      sat   [4];
  logic [1:0]                ml;
  logic                      bad_d;

  always_comb begin
    ml    = main_lane(dbr_q[Q_W]);
    bad_d = dflg_q[Q_W];
    for (int l = 0; l < 4; l++) begin
      if (ml == 2'(l)) begin
        val[l] = $signed(V_W'(half_q[Q_W]));
      end else if (dneg_q[Q_W][l]) begin
        val[l] = -$signed(V_W'(dquo_q[Q_W][l]));
      end else begin
        val[l] = $signed(V_W'(dquo_q[Q_W][l]));
      end
      sat[l] = 1'b1;
      if (val[l] > VMAX) begin
        comp_d[l] = FIELD_W'(VMAX);
      end else if (val[l] < VMIN) begin
        comp_d[l] = FIELD_W'(VMIN);
      end else begin
        comp_d[l] = FIELD_W'(val[l]);
        sat[l]    = 1'b0;
      end
      bad_d = bad_d | sat[l];
    end
  end

  // output register
  logic                      vo_q;
  logic signed [FIELD_W-1:0] comp_q [4];
  logic [1:0]                bro_q;
  logic                      bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= dv_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      comp_q <= comp_d;
      bro_q  <= dbr_q[Q_W];
      bad_q  <= bad_d;
    end
  end

  assign valid_o        = vo_q;
  assign quat_x_o       = comp_q[LANE_X];
  assign quat_y_o       = comp_q[LANE_Y];
  assign quat_z_o       = comp_q[LANE_Z];
  assign quat_w_o       = comp_q[LANE_W];
  assign branch_taken_o = bro_q;
  assign bad_input_o    = bad_q;

  // ---------------------------------------------------------------- assertions
  // a waiting result is still there next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(quat_w_o) && $stable(branch_taken_o))
    else $error("held result changed");

  // the root-derived component is never negative; checked here on the trace and r0c0 paths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && branch_taken_o == BR_TRACE |-> !quat_w_o[FIELD_W-1])
    else $error("negative w on trace path");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && branch_taken_o == BR_R0C0 |-> !quat_x_o[FIELD_W-1])
    else $error("negative x on r0c0 path");

endmodule
